// ===== src/plb_pkg.sv =====
`timescale 1ns / 1ps

package plb_pkg;

  localparam int CAPACITY_DEF = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_PRINT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

endpackage

// ===== src/plb_in_if.sv =====
`timescale 1ns / 1ps

interface plb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] position;
  logic [7:0] char_in;

  modport source (output valid, cmd, position, char_in, input ready);
  modport sink (input valid, cmd, position, char_in, output ready);
endinterface

// ===== src/plb_out_if.sv =====
`timescale 1ns / 1ps

interface plb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] char_out;
  logic       has_char;
  logic       last;

  modport source (output valid, status, char_out, has_char, last, input ready);
  modport sink (input valid, status, char_out, has_char, last, output ready);
endinterface

// ===== src/plb_store.sv =====
`timescale 1ns / 1ps

module plb_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/positional_list_buffer_unit.sv =====
`timescale 1ns / 1ps
// Positional list buffer: an ordered list of up to CAPACITY bytes addressed
// by 1-based rank. Commands arrive as words on in_ch (cmd, position,
// char_in); results leave as words on out_ch (status, char_out, has_char,
// last). Every command gives at least one result word; the final one has
// last set. Print gives one word per stored byte, or a single empty word.
// One command is worked at a time; in_ch.ready is high only while idle.
// Entries live in a one-port-read, one-port-write memory with registered
// read data, and a single index counter walks it one entry per step:
//   add:    shifts entries at position and above up by one, then writes the byte
//   delete: shifts entries after position down by one, then shrinks the list
//   get:    reads the entry at position; errors and an empty print go straight to the result
//   print:  reads each byte and loads it into the output register in turn
// Each moved entry costs a memory read followed by a write. A result sits
// in an output register; the next command is accepted while it waits.
// When out_ch stalls, the sequencer holds until the register frees up.
// Reset (synchronous, rst_n low) empties the list and drops any pending
// result; memory contents are left as they are and never read unwritten.
module positional_list_buffer_unit
  import plb_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  plb_in_if.sink    in_ch,
  plb_out_if.source out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ADD_RD  = 9'b000000010,
    S_ADD_WR  = 9'b000000100,
    S_DEL_RD  = 9'b000001000,
    S_DEL_WR  = 9'b000010000,
    S_GET_RD  = 9'b000100000,
    S_PR_RD   = 9'b001000000,
    S_PR_OUT  = 9'b010000000,
    S_RESP    = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   p0_r, p0_nxt;
  logic [7:0]      char_r;
  status_t         resp_status_r, resp_status_nxt;
  logic            resp_has_r, resp_has_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r;
  logic [7:0]      out_char_r;
  logic            out_has_r, out_last_r;
  logic            out_load;
  status_t         load_status;
  logic [7:0]      load_char;
  logic            load_has, load_last;

  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [7:0]      rd_data, wr_data;

  logic            in_acc, slot_free;
  logic [8:0]      pos9, cnt9;
  logic [7:0]      pos_m1;
  logic            bad_add, bad_rd, is_full;
  logic [CW-1:0]   idx_inc;
  cmd_t            in_cmd;

  plb_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_cmd      = cmd_t'(in_ch.cmd);
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign pos9    = {1'b0, in_ch.position};
  assign cnt9    = 9'(count_r);
  assign pos_m1  = in_ch.position - 8'd1;
  assign bad_add = (in_ch.position == 8'd0) || (pos9 > cnt9 + 9'd1);
  assign bad_rd  = (in_ch.position == 8'd0) || (pos9 > cnt9);
  assign is_full = (count_r == CAP_C);
  assign idx_inc = CW'(idx_r) + CW'(1);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    p0_nxt          = p0_r;
    resp_status_nxt = resp_status_r;
    resp_has_nxt    = resp_has_r;
    rd_en           = 1'b0;
    rd_addr         = idx_r;
    wr_en           = 1'b0;
    wr_addr         = idx_r;
    wr_data         = rd_data;
    out_load        = 1'b0;
    load_status     = resp_status_r;
    load_char       = resp_has_r ? rd_data : 8'd0;
    load_has        = resp_has_r;
    load_last       = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          p0_nxt          = pos_m1[AW-1:0];
          resp_status_nxt = ST_OK;
          resp_has_nxt    = 1'b0;
          unique case (in_cmd)
            CMD_ADD: begin
              if (bad_add) begin
                resp_status_nxt = ST_INVALID;
                state_nxt       = S_RESP;
              end else if (is_full) begin
                resp_status_nxt = ST_FULL;
                state_nxt       = S_RESP;
              end else begin
                idx_nxt   = count_r[AW-1:0];
                state_nxt = S_ADD_RD;
              end
            end
            CMD_DELETE: begin
              if (bad_rd) begin
                resp_status_nxt = ST_INVALID;
                state_nxt       = S_RESP;
              end else begin
                idx_nxt   = pos_m1[AW-1:0];
                state_nxt = S_DEL_RD;
              end
            end
            CMD_GET: begin
              if (bad_rd) begin
                resp_status_nxt = ST_INVALID;
                state_nxt       = S_RESP;
              end else begin
                resp_has_nxt = 1'b1;
                state_nxt    = S_GET_RD;
              end
            end
            CMD_PRINT: begin
              idx_nxt   = '0;
              state_nxt = (count_r == '0) ? S_RESP : S_PR_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: begin
        if (idx_r == p0_r) begin
          // drop the new byte into the opened slot
          wr_en     = 1'b1;
          wr_addr   = p0_r;
          wr_data   = char_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_r - AW'(1);
          state_nxt = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_r - AW'(1);
        state_nxt = S_ADD_RD;
      end
      S_DEL_RD: begin
        if (idx_inc >= count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_inc[AW-1:0];
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_inc[AW-1:0];
        state_nxt = S_DEL_RD;
      end
      S_GET_RD: begin
        rd_en     = 1'b1;
        rd_addr   = p0_r;
        state_nxt = S_RESP;
      end
      S_PR_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_PR_OUT;
      end
      S_PR_OUT: begin
        load_status = ST_OK;
        load_char   = rd_data;
        load_has    = 1'b1;
        load_last   = (idx_inc == count_r);
        if (slot_free) begin
          out_load = 1'b1;
          if (load_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_inc[AW-1:0];
            state_nxt = S_PR_RD;
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    p0_r          <= p0_nxt;
    resp_status_r <= resp_status_nxt;
    resp_has_r    <= resp_has_nxt;
    if (in_acc) begin
      char_r <= in_ch.char_in;
    end
    if (out_load) begin
      out_status_r <= load_status;
      out_char_r   <= load_char;
      out_has_r    <= load_has;
      out_last_r   <= load_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.has_char = out_has_r;
  assign out_ch.last     = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("list count above capacity");

  a_add_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_WR) |-> (idx_r > p0_r))
    else $error("add shift moved past the insert slot");

  a_del_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL_WR) |-> (idx_inc < count_r))
    else $error("delete shift read beyond the list end");

  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ($past(state_r) == S_ADD_RD || $past(state_r) == S_DEL_RD))
    else $error("count changed outside an add or delete finish");

  a_print_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PR_OUT && !slot_free) |=> (state_r == S_PR_OUT))
    else $error("print advanced while output stalled");

endmodule
